FILE: design/lpdr_pkg.sv
// Package for the length-prefix deframer: status codes, header state,
// default sizes and the result structures passed between the modules.
// No dependencies.
package lpdr_pkg;

  localparam int DEF_RING_SLOTS = 4;
  localparam int DEF_SLOT_BYTES = 16384;

  localparam int MAX_LEN_W = 15;
  localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = 15'd9000;

  localparam logic ACT_OFFER = 1'b0;
  localparam logic ACT_POP   = 1'b1;

  // Output queue depth covers the memory read stage plus output stall slack.
  localparam int OQ_DEPTH = 3;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_REFUSED  = 3'd1,
    ST_QUEUED   = 3'd2,
    ST_DROPPED  = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    HDR_HI,
    HDR_LO,
    HDR_PAYLOAD
  } hdr_state_t;

  typedef struct packed {
    status_t    status;
    logic       byte_valid;
    logic       last;
    logic [1:0] frames;
  } res_t;

  typedef struct packed {
    status_t    status;
    logic       byte_valid;
    logic [7:0] data;
    logic       last;
    logic [1:0] frames;
  } out_item_t;

endpackage

FILE: design/length_prefix_deframer_ring.sv
// Top level of the length-prefix deframer with a ring of frame slots.
// Instantiates lpdr_ctrl, lpdr_slot_mem and lpdr_out_queue; uses lpdr_pkg.
//
// The block takes one item per clock cycle on the input channel, either a
// stream byte or a pop request, and returns exactly one result item for each,
// in order. Framing state and ring pointers are updated in the cycle an item
// is accepted, so items may follow each other in every cycle. A popped byte
// comes from the single-port slot memory, whose read is registered alongside
// the result register; the output queue then takes both. A three-entry
// output queue absorbs the memory read stage and output stalls; in_stall
// rises only when that queue and the read stage together hold three items.
// The limit register may be written only while no items are in flight.
module length_prefix_deframer_ring import lpdr_pkg::*; #(
  parameter int RING_SLOTS = DEF_RING_SLOTS,
  parameter int SLOT_BYTES = DEF_SLOT_BYTES
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [MAX_LEN_W-1:0] cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_action,
  input  logic [7:0]           in_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           out_status,
  output logic                 out_byte_valid,
  output logic [7:0]           out_byte,
  output logic                 out_last,
  output logic [1:0]           out_frames_queued
);

  localparam int MEM_DEPTH = RING_SLOTS * SLOT_BYTES;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  logic                accept;
  logic                mem_we, mem_re;
  logic [ADDR_W-1:0]   mem_addr;
  logic [7:0]          mem_wdata, mem_rdata;
  logic                res_valid;
  res_t                res;
  out_item_t           head;
  logic [OQ_CNT_W-1:0] q_count;
  logic [OQ_CNT_W:0]   in_flight;

  assign in_flight = {1'b0, q_count} + (OQ_CNT_W + 1)'(res_valid);
  assign in_stall  = (in_flight >= (OQ_CNT_W + 1)'(OQ_DEPTH));
  assign accept    = in_valid && !in_stall;

  lpdr_ctrl #(
    .RING_SLOTS (RING_SLOTS),
    .SLOT_BYTES (SLOT_BYTES),
    .ADDR_W     (ADDR_W)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (accept),
    .action      (in_action),
    .in_byte     (in_byte),
    .mem_we      (mem_we),
    .mem_re      (mem_re),
    .mem_addr    (mem_addr),
    .mem_wdata   (mem_wdata),
    .res_valid   (res_valid),
    .res         (res)
  );

  lpdr_slot_mem #(
    .DEPTH  (MEM_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  lpdr_out_queue u_oq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .res       (res),
    .rdata     (mem_rdata),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .head      (head),
    .count     (q_count)
  );

  assign out_status        = head.status;
  assign out_byte_valid    = head.byte_valid;
  assign out_byte          = head.data;
  assign out_last          = head.last;
  assign out_frames_queued = head.frames;

endmodule

FILE: design/lpdr_slot_mem.sv
// Byte store for all ring slots: one write or one read per cycle,
// read data registered. Depends on nothing outside this file.
module lpdr_slot_mem #(
  parameter int DEPTH  = 65536,
  parameter int ADDR_W = 16
) (
  input  logic              clk,
  input  logic              we,
  input  logic              re,
  input  logic [ADDR_W-1:0] addr,
  input  logic [7:0]        wdata,
  output logic [7:0]        rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: design/lpdr_ctrl.sv
// Deframer control: header parsing, slot ring pointers, frame lengths and
// the limit register. Issues slot memory accesses. Uses lpdr_pkg.
module lpdr_ctrl import lpdr_pkg::*; #(
  parameter int RING_SLOTS = DEF_RING_SLOTS,
  parameter int SLOT_BYTES = DEF_SLOT_BYTES,
  parameter int ADDR_W     = $clog2(RING_SLOTS * SLOT_BYTES)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [MAX_LEN_W-1:0] cfg_wr_data,
  input  logic                 accept,
  input  logic                 action,
  input  logic [7:0]           in_byte,
  output logic                 mem_we,
  output logic                 mem_re,
  output logic [ADDR_W-1:0]    mem_addr,
  output logic [7:0]           mem_wdata,
  output logic                 res_valid,
  output res_t                 res
);

  localparam int SLOT_W = $clog2(RING_SLOTS);
  localparam int LEN_W  = $clog2(SLOT_BYTES + 1);

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    next_slot = (s == SLOT_W'(RING_SLOTS - 1)) ? '0 : s + 1'b1;
  endfunction

  hdr_state_t           state_r, state_nxt;
  logic [MAX_LEN_W-1:0] max_len_r;
  logic [SLOT_W-1:0]    fill_r, fill_nxt, drain_r, drain_nxt;
  logic [7:0]           len_hi_r, len_hi_nxt;
  logic [15:0]          rem_r, rem_nxt, rem_dec;
  logic [LEN_W-1:0]     fpos_r, fpos_nxt, fpos_inc;
  logic [LEN_W-1:0]     dpos_r, dpos_nxt, dpos_inc;
  logic                 wait_r, wait_nxt;
  logic                 disc_r, disc_nxt;
  logic [LEN_W-1:0]     slot_len [RING_SLOTS];
  logic                 len_we;
  logic [15:0]          hdr_len;
  logic [SLOT_W:0]      q_diff;
  logic                 res_valid_r;
  res_t                 res_r, res_nxt;

  assign hdr_len  = {len_hi_r, in_byte};
  assign fpos_inc = fpos_r + 1'b1;
  assign dpos_inc = dpos_r + 1'b1;
  assign rem_dec  = (rem_r != 16'd0) ? rem_r - 16'd1 : rem_r;
  assign mem_wdata = in_byte;

  always_comb begin
    state_nxt  = state_r;
    fill_nxt   = fill_r;
    drain_nxt  = drain_r;
    len_hi_nxt = len_hi_r;
    rem_nxt    = rem_r;
    fpos_nxt   = fpos_r;
    dpos_nxt   = dpos_r;
    wait_nxt   = wait_r;
    disc_nxt   = disc_r;
    len_we     = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_addr   = ADDR_W'(fill_r) * ADDR_W'(SLOT_BYTES) + ADDR_W'(fpos_r);
    res_nxt    = '{status: ST_OK, byte_valid: 1'b0, last: 1'b0, frames: 2'd0};
    if (action == ACT_OFFER) begin
      if (wait_r) begin
        res_nxt.status = ST_REFUSED;
      end else begin
        unique case (state_r)
          HDR_HI: begin
            len_hi_nxt = in_byte;
            state_nxt  = HDR_LO;
          end
          HDR_LO: begin
            if (hdr_len == 16'd0) begin
              state_nxt      = HDR_HI;
              res_nxt.status = ST_DROPPED;
            end else begin
              state_nxt = HDR_PAYLOAD;
              rem_nxt   = hdr_len;
              fpos_nxt  = '0;
              disc_nxt  = (hdr_len > {1'b0, max_len_r}) ||
                          ({1'b0, hdr_len} > 17'(SLOT_BYTES));
            end
          end
          HDR_PAYLOAD: begin
            if (!disc_r) begin
              mem_we   = 1'b1;
              fpos_nxt = fpos_inc;
            end
            rem_nxt = rem_dec;
            if (rem_dec == 16'd0) begin
              state_nxt = HDR_HI;
              if (disc_r) begin
                disc_nxt       = 1'b0;
                res_nxt.status = ST_DROPPED;
              end else begin
                len_we         = 1'b1;
                fpos_nxt       = '0;
                res_nxt.status = ST_QUEUED;
                if (next_slot(fill_r) != drain_r) begin
                  fill_nxt = next_slot(fill_r);
                end else begin
                  wait_nxt = 1'b1;
                end
              end
            end
          end
          default: begin
            state_nxt = HDR_HI;
          end
        endcase
      end
    end else if (drain_r == fill_r) begin
      res_nxt.status = ST_EMPTY;
    end else begin
      mem_re             = 1'b1;
      mem_addr           = ADDR_W'(drain_r) * ADDR_W'(SLOT_BYTES) + ADDR_W'(dpos_r);
      res_nxt.byte_valid = 1'b1;
      if (dpos_inc >= slot_len[drain_r]) begin
        res_nxt.last = 1'b1;
        dpos_nxt     = '0;
        drain_nxt    = next_slot(drain_r);
        if (wait_r) begin
          fill_nxt = next_slot(fill_r);
          wait_nxt = 1'b0;
        end
      end else begin
        dpos_nxt = dpos_inc;
      end
    end
    q_diff = {1'b0, fill_nxt} - {1'b0, drain_nxt};
    if (fill_nxt < drain_nxt) begin
      q_diff = q_diff + (SLOT_W + 1)'(RING_SLOTS);
    end
    res_nxt.frames = (q_diff > (SLOT_W + 1)'(3)) ? 2'd3 : q_diff[1:0];
    if (!accept) begin
      state_nxt  = state_r;
      fill_nxt   = fill_r;
      drain_nxt  = drain_r;
      len_hi_nxt = len_hi_r;
      rem_nxt    = rem_r;
      fpos_nxt   = fpos_r;
      dpos_nxt   = dpos_r;
      wait_nxt   = wait_r;
      disc_nxt   = disc_r;
      len_we     = 1'b0;
      mem_we     = 1'b0;
      mem_re     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= HDR_HI;
      max_len_r   <= MAX_LEN_RESET;
      fill_r      <= '0;
      drain_r     <= '0;
      len_hi_r    <= '0;
      rem_r       <= '0;
      fpos_r      <= '0;
      dpos_r      <= '0;
      wait_r      <= 1'b0;
      disc_r      <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      drain_r     <= drain_nxt;
      len_hi_r    <= len_hi_nxt;
      rem_r       <= rem_nxt;
      fpos_r      <= fpos_nxt;
      dpos_r      <= dpos_nxt;
      wait_r      <= wait_nxt;
      disc_r      <= disc_nxt;
      res_valid_r <= accept;
      if (cfg_wr_en) begin
        max_len_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (len_we) begin
      slot_len[fill_r] <= fpos_inc;
    end
    if (accept) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

FILE: design/lpdr_out_queue.sv
// Output queue: joins each result with its slot memory read data and holds
// up to OQ_DEPTH items for the output channel. Uses lpdr_pkg.
module lpdr_out_queue import lpdr_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  res_t                res,
  input  logic [7:0]          rdata,
  input  logic                out_stall,
  output logic                out_valid,
  output out_item_t           head,
  output logic [OQ_CNT_W-1:0] count
);

  out_item_t           entry [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [OQ_CNT_W-1:0] count_r, count_nxt;
  logic                pop;
  out_item_t           item;

  function automatic logic [OQ_PTR_W-1:0] ptr_inc(input logic [OQ_PTR_W-1:0] p);
    ptr_inc = (p == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign out_valid = (count_r != '0);
  assign pop       = out_valid && !out_stall;

  always_comb begin
    item.status     = res.status;
    item.byte_valid = res.byte_valid;
    item.data       = res.byte_valid ? rdata : 8'd0;
    item.last       = res.last;
    item.frames     = res.frames;
    wr_ptr_nxt      = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt      = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt       = count_r + OQ_CNT_W'(push) - OQ_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr_r] <= item;
    end
  end

  assign head  = entry[rd_ptr_r];
  assign count = count_r;

endmodule

FILE: design/lpdr_checker.sv
// Port-level checks for length_prefix_deframer_ring and the bind that
// attaches them. Uses lpdr_pkg.
module lpdr_checker import lpdr_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [2:0]           out_status,
  input logic                 out_byte_valid,
  input logic [7:0]           out_byte,
  input logic                 out_last,
  input logic [1:0]           out_frames_queued
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_no_byte_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_byte_valid) |-> (out_byte == 8'd0 && !out_last))
    else $error("byte fields set without a popped byte");

  a_byte_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_byte_valid) |-> (out_status == ST_OK))
    else $error("popped byte with a non-ok status");

  a_no_frames_on_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_EMPTY) |-> (out_frames_queued == 2'd0))
    else $error("empty pop reported queued frames");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_byte) && $stable(out_status)))
    else $error("stalled output item changed");

endmodule

bind length_prefix_deframer_ring lpdr_checker u_lpdr_checker (.*);
